// ----- src/imm_pkg.sv -----
// Package of shared types and constants for the integer matrix multiplier.
`default_nettype none
package imm_pkg;

  // Width of a row or column index, and of the size registers.
  localparam int IDX_W  = 3;
  localparam int SIZE_W = 4;
  // Width of a product element.
  localparam int ACC_W  = 36;

  // Input item kinds carried in tuser.
  typedef enum logic [1:0] {
    CMD_LOAD_A = 2'd0,
    CMD_LOAD_B = 2'd1,
    CMD_START  = 2'd2,
    CMD_NONE   = 2'd3
  } imm_cmd_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ROWS_A     = 2'd0;
  localparam logic [1:0] CFG_INNER_SIZE = 2'd1;
  localparam logic [1:0] CFG_COLS_B     = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             issue;     // a pair of element reads is issued this cycle
    logic             first;     // first term of a dot product
    logic             last;      // last term of a dot product
    logic             run_last;  // this dot product is the final one of the run
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] k;
    logic             wr_a;      // store the loaded element into A
    logic             wr_b;      // store the loaded element into B
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic adv;                   // the pipeline moves on this cycle
  } dp_status_t;

endpackage
`default_nettype wire

// ----- src/imm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module imm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- src/imm_controller.sv -----
// Sequencer of the matrix multiplier: size registers, loads and the run loop.
`default_nettype none
module imm_controller #(
  parameter int MAX_DIM = 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [1:0]                 cfg_index,
  input  wire logic [imm_pkg::SIZE_W-1:0] cfg_data,
  input  wire logic                       s_tvalid,
  input  wire logic [1:0]                 command,
  input  wire logic [imm_pkg::IDX_W-1:0]  row_index,
  input  wire logic [imm_pkg::IDX_W-1:0]  col_index,
  output logic                            s_tready,
  output imm_pkg::dp_cmd_t                cmd,
  input  imm_pkg::dp_status_t             status
);
  import imm_pkg::*;

  localparam logic [SIZE_W-1:0] MAX_L = SIZE_W'(MAX_DIM);

  function automatic logic [SIZE_W-1:0] clamp_dim(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) r = SIZE_W'(1);
    else if (v > MAX_L) r = MAX_L;
    return r;
  endfunction

  logic [SIZE_W-1:0] rows_a, inner_size, cols_b;
  logic [SIZE_W-1:0] m_last, n_last, p_last;
  ctrl_state_t state, state_next;
  logic [IDX_W-1:0] i, j, k, i_next, j_next, k_next;
  logic accept, in_range, k_end, j_end, i_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a     <= SIZE_W'(1);
      inner_size <= SIZE_W'(1);
      cols_b     <= SIZE_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROWS_A:     rows_a     <= cfg_data;
        CFG_INNER_SIZE: inner_size <= cfg_data;
        CFG_COLS_B:     cols_b     <= cfg_data;
        default:        ;
      endcase
    end
  end

  assign m_last = clamp_dim(rows_a) - SIZE_W'(1);
  assign n_last = clamp_dim(inner_size) - SIZE_W'(1);
  assign p_last = clamp_dim(cols_b) - SIZE_W'(1);

  assign k_end = ({1'b0, k} == n_last);
  assign j_end = ({1'b0, j} == p_last);
  assign i_end = ({1'b0, i} == m_last);

  assign accept   = s_tvalid && s_tready;
  assign in_range = ({1'b0, row_index} < MAX_L) && ({1'b0, col_index} < MAX_L);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      i     <= '0;
      j     <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      i     <= i_next;
      j     <= j_next;
      k     <= k_next;
    end
  end

  always_comb begin
    state_next   = state;
    i_next       = i;
    j_next       = j;
    k_next       = k;
    s_tready     = 1'b0;
    cmd.issue    = 1'b0;
    cmd.first    = (k == '0);
    cmd.last     = k_end;
    cmd.run_last = i_end && j_end;
    cmd.row      = i;
    cmd.col      = j;
    cmd.k        = k;
    cmd.wr_a     = 1'b0;
    cmd.wr_b     = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.wr_a = accept && (command == CMD_LOAD_A) && in_range;
        cmd.wr_b = accept && (command == CMD_LOAD_B) && in_range;
        if (accept && (command == CMD_START)) begin
          state_next = ST_RUN;
          i_next     = '0;
          j_next     = '0;
          k_next     = '0;
        end
      end
      ST_RUN: begin
        cmd.issue = 1'b1;
        if (status.adv) begin
          if (!k_end) begin
            k_next = k + IDX_W'(1);
          end else begin
            k_next = '0;
            if (!j_end) begin
              j_next = j + IDX_W'(1);
            end else begin
              j_next = '0;
              if (!i_end) begin
                i_next = i + IDX_W'(1);
              end else begin
                state_next = ST_IDLE;
              end
            end
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

`ifndef SYNTH
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && !status.adv) |=> ($stable(i) && $stable(j) && $stable(k)))
    else $error("loop counters moved while the pipeline was stalled");

  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && status.adv && cmd.last && cmd.run_last) |=> (state == ST_IDLE))
    else $error("run did not end after its final read");
`endif

endmodule
`default_nettype wire

// ----- src/imm_datapath.sv -----
// Element stores, multiplier, accumulator and output register.
`default_nettype none
module imm_datapath #(
  parameter int MAX_DIM       = 8,
  parameter int ELEMENT_WIDTH = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  imm_pkg::dp_cmd_t               cmd,
  output imm_pkg::dp_status_t            status,
  input  wire logic [imm_pkg::IDX_W-1:0] row_index,
  input  wire logic [imm_pkg::IDX_W-1:0] col_index,
  input  wire logic signed [15:0]        element_value,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic signed [imm_pkg::ACC_W-1:0] out_value,
  output logic [imm_pkg::IDX_W-1:0]      out_row,
  output logic [imm_pkg::IDX_W-1:0]      out_col,
  output logic                           out_last
);
  import imm_pkg::*;

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PROD_W = 2 * ELEMENT_WIDTH;

  logic adv;
  logic [ELEMENT_WIDTH-1:0] wdata;
  logic [ADDR_W-1:0] waddr, a_raddr, b_raddr;
  logic signed [ELEMENT_WIDTH-1:0] a_rdata, b_rdata;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0] prod_ext, acc, acc_sum;

  logic valid1, first1, last1, rl1;
  logic valid2, first2, last2, rl2;
  logic [IDX_W-1:0] row1, col1, row2, col2;

  assign adv        = !out_valid || out_ready;
  assign status.adv = adv;

  // A loaded element is sign-extended from 16 bits and wrapped to the store width.
  if (ELEMENT_WIDTH <= 16) begin : g_narrow
    assign wdata = element_value[ELEMENT_WIDTH-1:0];
  end else begin : g_wide
    assign wdata = {{(ELEMENT_WIDTH-16){element_value[15]}}, element_value};
  end

  assign waddr   = ADDR_W'(ADDR_W'(row_index) * ADDR_W'(MAX_DIM) + ADDR_W'(col_index));
  assign a_raddr = ADDR_W'(ADDR_W'(cmd.row) * ADDR_W'(MAX_DIM) + ADDR_W'(cmd.k));
  assign b_raddr = ADDR_W'(ADDR_W'(cmd.k) * ADDR_W'(MAX_DIM) + ADDR_W'(cmd.col));

  imm_ram #(.WIDTH(ELEMENT_WIDTH), .DEPTH(DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (cmd.wr_a),
    .waddr (waddr),
    .wdata (wdata),
    .re    (adv),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  imm_ram #(.WIDTH(ELEMENT_WIDTH), .DEPTH(DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (cmd.wr_b),
    .waddr (waddr),
    .wdata (wdata),
    .re    (adv),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  if (PROD_W >= ACC_W) begin : g_trunc
    assign prod_ext = prod[ACC_W-1:0];
  end else begin : g_sext
    assign prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
  end

  assign acc_sum = (first2 ? '0 : acc) + prod_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1    <= 1'b0;
      valid2    <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      valid1    <= cmd.issue;
      valid2    <= valid1;
      out_valid <= valid2 && last2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      first1 <= cmd.first;
      last1  <= cmd.last;
      rl1    <= cmd.run_last;
      row1   <= cmd.row;
      col1   <= cmd.col;
      first2 <= first1;
      last2  <= last1;
      rl2    <= rl1;
      row2   <= row1;
      col2   <= col1;
      prod   <= a_rdata * b_rdata;
      if (valid2) begin
        acc <= acc_sum;
        if (last2) begin
          out_value <= acc_sum;
          out_row   <= row2;
          out_col   <= col2;
          out_last  <= rl2;
        end
      end
    end
  end

`ifndef SYNTH
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (valid2 && last2 && adv) |=> out_valid)
    else $error("finished dot product was not presented");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(valid2 && last2))
    else $error("result presented without a finished dot product");
`endif

endmodule
`default_nettype wire

// ----- src/integer_matrix_multiply.sv -----
// Top level of the signed integer matrix multiplier with stream ports.
`default_nettype none
// Multiplies A (rows_a by inner_size) by B (inner_size by cols_b), both held as signed
// elements of ELEMENT_WIDTH bits. Each input transaction is either a load of one element
// into A or B, or a start. A start makes the block walk the product in row-major order
// and emit one output transaction per element, carrying its 36-bit value, its row, its
// column and tlast on the final element. Each product element takes inner_size
// multiplies, one element of A by one element of B a cycle while the output is not
// stalled, through the single multiplier and accumulator, and a run keeps the input
// closed until its last pair of reads is issued. Each result passes through the
// registered reads of the stores, the product register and the output register after
// the last pair of reads of its dot product. Back-pressure on the output holds the whole
// pipeline. The size registers read 0 as 1 and anything above MAX_DIM as MAX_DIM; loads
// outside the store are dropped, as is the unused item kind. Reading an element that was
// never loaded gives an undefined value.
module integer_matrix_multiply #(
  parameter int MAX_DIM       = 8,
  parameter int ELEMENT_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration writes: index 0 rows_a, 1 inner_size, 2 cols_b.
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [3:0]  cfg_data,
  // Input stream.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // row_index[2:0], col_index[5:3], element_value[21:6]
  input  wire logic [1:0]  s_tuser,   // command[1:0]
  // Output stream.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // product_value[35:0], product_row[38:36],
                                      // product_col[41:39]
  output logic             m_tlast    // last_element
);
  import imm_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic [IDX_W-1:0] row_index, col_index, product_row, product_col;
  logic signed [15:0] element_value;
  logic signed [ACC_W-1:0] product_value;

  // Unpack the fields of an input transaction.
  assign row_index     = s_tdata[2:0];
  assign col_index     = s_tdata[5:3];
  assign element_value = s_tdata[21:6];

  // The controller owns the size registers and the loop over rows, columns and the
  // inner dimension; it keeps the input closed while a run issues its reads.
  imm_controller #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .command   (s_tuser),
    .row_index (row_index),
    .col_index (col_index),
    .s_tready  (s_tready),
    .cmd       (cmd),
    .status    (status)
  );

  // The datapath holds both stores and the read, multiply, accumulate pipeline, ending
  // in the output register.
  imm_datapath #(.MAX_DIM(MAX_DIM), .ELEMENT_WIDTH(ELEMENT_WIDTH)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .row_index     (row_index),
    .col_index     (col_index),
    .element_value (element_value),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_value     (product_value),
    .out_row       (product_row),
    .out_col       (product_col),
    .out_last      (m_tlast)
  );

  // Pack the output transaction, with the spare top bits held at zero.
  assign m_tdata = {6'd0, product_col, product_row, product_value};

endmodule
`default_nettype wire
